FILE: rtl/core/wlmd_pkg.sv
// shared types and constants of the window local minimum detector
package wlmd_pkg;

   localparam int COORD_W  = 16;
   localparam int DIST_W   = 24;
   localparam int POS_W    = 16;
   localparam int RADIUS_W = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [RADIUS_W-1:0]       radius_type;

   localparam radius_type RADIUS_RESET = 5'd1;
   localparam pos_type    COUNT_MAX    = 16'hFFFF;

   typedef struct packed {
      coord_type x;
      coord_type y;
      dist_type  d;
   } slot_type;

endpackage

FILE: rtl/core/window_local_minimum_detector.sv
// window local minimum detector: shift window, center test and result register
// a window is registered with the transaction that completes it, then tested;
// the result of the test is registered on rsp_ once the result register is free
// throughput: one transaction per cycle unless stalled; single shift window register
// reset: synchronous; clears the item count, pipeline valids and sets the radius to 1
module window_local_minimum_detector #(
   parameter int MAX_RADIUS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wlmd_pkg::coord_type    req_point_x,
   input  wlmd_pkg::coord_type    req_point_y,
   input  wlmd_pkg::dist_type     req_dist_value,
   input  logic                   req_seq_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output wlmd_pkg::coord_type    rsp_min_x,
   output wlmd_pkg::coord_type    rsp_min_y,
   output wlmd_pkg::pos_type      rsp_min_position,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  wlmd_pkg::radius_type   csr_window_radius
);
   import wlmd_pkg::*;

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int IDX_W = $clog2(DEPTH);

   radius_type          radius_ff;
   pos_type             cnt_ff, cnt_in;
   slot_type            window_ff [DEPTH];
   slot_type            window_in [DEPTH];

   logic                s1_vld_ff, s1_vld_in;
   logic                s1_chk_ff;
   logic [IDX_W-1:0]    s1_cen_ff;
   logic [IDX_W-1:0]    s1_lst_ff;
   pos_type             s1_pos_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   coord_type           rsp_x_ff, rsp_y_ff;
   pos_type             rsp_pos_ff;

   logic                req_acc, adv;
   logic [IDX_W-1:0]    eff_rad;
   logic [IDX_W:0]      span;
   pos_type             n_sat;
   logic [IDX_W-1:0]    n_small;
   logic                full_win;
   logic                chk_in;
   logic [IDX_W-1:0]    cen_in, lst_in;
   pos_type             pos_in;
   slot_type            cen_slot;
   logic                hit;

   assign csr_ready = 1'b1;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || adv;
   assign req_acc   = req_valid && req_ready;

   // effective radius and window decision for the incoming transaction
   always_comb begin
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         eff_rad = IDX_W'(MAX_RADIUS);
      end else begin
         eff_rad = IDX_W'(radius_ff);
      end
      span     = {eff_rad, 1'b0} + (IDX_W+1)'(1);
      n_sat    = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + 16'd1;
      n_small  = n_sat[IDX_W-1:0];
      full_win = (n_sat >= POS_W'(span));
      chk_in   = full_win || (req_seq_last && n_sat[0]);
      if (full_win) begin
         cen_in = eff_rad;
         lst_in = IDX_W'({eff_rad, 1'b0});
         pos_in = cnt_ff - POS_W'(eff_rad);
      end else begin
         cen_in = n_small >> 1;
         lst_in = n_small - IDX_W'(1);
         pos_in = POS_W'(n_small >> 1);
      end
      cnt_in = req_seq_last ? '0 : n_sat;
   end

   always_comb begin
      window_in[0] = '{x: req_point_x, y: req_point_y, d: req_dist_value};
      for (int i = 1; i < DEPTH; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   // center test against every stored item up to the last one in range
   always_comb begin
      cen_slot = window_ff[s1_cen_ff];
      hit      = s1_chk_ff;
      for (int k = 0; k < DEPTH; k++) begin
         if ((IDX_W'(k) <= s1_lst_ff) && (cen_slot.d > window_ff[k].d)) begin
            hit = 1'b0;
         end
      end
   end

   assign s1_vld_in    = req_acc ? 1'b1 : (adv ? 1'b0 : s1_vld_ff);
   assign rsp_valid_in = adv ? (s1_vld_ff && hit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         cnt_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            radius_ff <= csr_window_radius;
         end
         if (req_acc) begin
            cnt_ff <= cnt_in;
         end
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         window_ff <= window_in;
         s1_chk_ff <= chk_in;
         s1_cen_ff <= cen_in;
         s1_lst_ff <= lst_in;
         s1_pos_ff <= pos_in;
      end
      if (adv && s1_vld_ff && hit) begin
         rsp_x_ff   <= cen_slot.x;
         rsp_y_ff   <= cen_slot.y;
         rsp_pos_ff <= s1_pos_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_x        = rsp_x_ff;
   assign rsp_min_y        = rsp_y_ff;
   assign rsp_min_position = rsp_pos_ff;

endmodule

FILE: rtl/core/wlmd_checker.sv
// port checker for the window local minimum detector and its bind
module wlmd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input wlmd_pkg::coord_type   rsp_min_x,
   input wlmd_pkg::coord_type   rsp_min_y,
   input wlmd_pkg::pos_type     rsp_min_position,
   input logic                  csr_valid,
   input logic                  csr_ready
);
   import wlmd_pkg::*;

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_x) && $stable(rsp_min_y)
         && $stable(rsp_min_position))
      else $error("result changed while stalled");

   // no result right after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register never blocks the input side
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // config writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write not taken");

endmodule

bind window_local_minimum_detector wlmd_checker u_wlmd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_min_x        (rsp_min_x),
   .rsp_min_y        (rsp_min_y),
   .rsp_min_position (rsp_min_position),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

FILE: dv/wlmd_minimum_checker.sv
// checker of the window local minimum detector: predicts each minimum and compares results
`timescale 1ns / 100ps
module wlmd_minimum_checker #(
   parameter int MAX_RADIUS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  wlmd_pkg::coord_type  req_point_x,
   input  wlmd_pkg::coord_type  req_point_y,
   input  wlmd_pkg::dist_type   req_dist_value,
   input  logic                 req_seq_last,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wlmd_pkg::coord_type  rsp_min_x,
   input  wlmd_pkg::coord_type  rsp_min_y,
   input  wlmd_pkg::pos_type    rsp_min_position,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  wlmd_pkg::radius_type csr_window_radius,
   output int                   fail_count,
   output int                   pending,
   output int                   item_total,
   output int                   result_total
);
   import wlmd_pkg::*;

   localparam int DEPTH = 2 * MAX_RADIUS + 1;

   typedef struct packed {
      coord_type x;
      coord_type y;
      pos_type   pos;
   } minimum_type;

   slot_type    window [DEPTH];
   int unsigned seq_count;
   radius_type  radius;
   minimum_type minima_queue [$];

   function automatic bit center_is_min(int unsigned center, int unsigned last);
      for (int unsigned k = 0; k <= last && k < DEPTH; k++) begin
         if (window[center].d > window[k].d) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   task automatic predict_minimum(coord_type px, coord_type py, dist_type pd, logic last);
      int unsigned newest;
      int unsigned n;
      int unsigned r;
      int unsigned m;
      minimum_type hit_entry;
      newest = seq_count;
      for (int k = DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = '{x: px, y: py, d: pd};
      n = (newest < COUNT_MAX) ? newest + 1 : COUNT_MAX;
      seq_count = n;
      r = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
      if (n >= 2 * r + 1) begin
         if (center_is_min(r, 2 * r)) begin
            hit_entry = '{window[r].x, window[r].y, pos_type'(newest - r)};
            minima_queue = {minima_queue, hit_entry};
         end
      end else if (last && (n % 2 == 1)) begin
         m = (n - 1) / 2;
         if (center_is_min(m, n - 1)) begin
            hit_entry = '{window[m].x, window[m].y, pos_type'(m)};
            minima_queue = {minima_queue, hit_entry};
         end
      end
      if (last) seq_count = 0;
   endtask

   always @(posedge clock) begin
      minimum_type want;
      if (reset) begin
         seq_count = 0;
         radius = RADIUS_RESET;
         minima_queue.delete();
      end else begin
         if (csr_valid && csr_ready) radius = csr_window_radius;
         if (rsp_valid && rsp_ready) begin
            result_total++;
            if (minima_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transaction, expected none actual x=%0d y=%0d pos=%0d",
                        $time, rsp_min_x, rsp_min_y, rsp_min_position);
            end else begin
               want = minima_queue.pop_front();
               check_field("min_x", want.x, rsp_min_x);
               check_field("min_y", want.y, rsp_min_y);
               check_field("min_position", {16'd0, want.pos}, {16'd0, rsp_min_position});
            end
         end
         if (req_valid && req_ready) begin
            item_total++;
            predict_minimum(req_point_x, req_point_y, req_dist_value, req_seq_last);
         end
      end
      pending = minima_queue.size();
   end

endmodule

FILE: dv/window_local_minimum_detector_tb.sv
// testbench top of the window local minimum detector: stimulus, idling and verdict
`timescale 1ns / 100ps
module window_local_minimum_detector_tb;
   import wlmd_pkg::*;

   localparam int MAX_RADIUS   = 16;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 6;
   localparam int RANDOM_ITEMS = 800;
   localparam int LONG_RUN     = 200;
   localparam int PLAN_SIZE    = 8;
   localparam radius_type RADIUS_PLAN [PLAN_SIZE] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd31,
                                                      5'd4, 5'd8};

   typedef enum {DIST_TIES, DIST_WIDE, DIST_VALLEY} dist_shape_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   coord_type  req_point_x;
   coord_type  req_point_y;
   dist_type   req_dist_value;
   logic       req_seq_last;
   logic       rsp_valid;
   logic       rsp_ready;
   coord_type  rsp_min_x;
   coord_type  rsp_min_y;
   pos_type    rsp_min_position;
   logic       csr_valid;
   logic       csr_ready;
   radius_type csr_window_radius;

   int fail_count;
   int pending;
   int item_total;
   int result_total;
   int cycle_count;
   int sent_items;
   bit send_idle;
   bit recv_idle;

   window_local_minimum_detector #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_dist_value   (req_dist_value),
      .req_seq_last     (req_seq_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_x        (rsp_min_x),
      .rsp_min_y        (rsp_min_y),
      .rsp_min_position (rsp_min_position),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_radius(csr_window_radius)
   );

   wlmd_minimum_checker #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_dist_value   (req_dist_value),
      .req_seq_last     (req_seq_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_x        (rsp_min_x),
      .rsp_min_y        (rsp_min_y),
      .rsp_min_position (rsp_min_position),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_radius(csr_window_radius),
      .fail_count       (fail_count),
      .pending          (pending),
      .item_total       (item_total),
      .result_total     (result_total)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !recv_idle || ($urandom_range(99) >= 25);
      end
   end

   task automatic send_point(coord_type px, coord_type py, dist_type pd, logic last);
      while (send_idle && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= px;
      req_point_y    <= py;
      req_dist_value <= pd;
      req_seq_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(radius_type value);
      wait_idle();
      csr_valid         <= 1'b1;
      csr_window_radius <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sequence(int len, dist_shape_type shape);
      dist_type d;
      int half;
      half = len / 2;
      for (int i = 0; i < len; i++) begin
         case (shape)
            DIST_TIES: d = dist_type'($urandom_range(7));
            DIST_WIDE: d = dist_type'($urandom);
            default:   d = dist_type'(((i < half) ? half - i : i - half) * 4
                                      + $urandom_range(3));
         endcase
         send_point(coord_type'($urandom), coord_type'($urandom), d, i == len - 1);
      end
   endtask

   initial begin
      radius_type     value;
      int             eff;
      int             len;
      int             phase;
      int             target;
      dist_shape_type shape;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_point_x       = '0;
      req_point_y       = '0;
      req_dist_value    = '0;
      req_seq_last      = 1'b0;
      csr_valid         = 1'b0;
      csr_window_radius = '0;
      sent_items        = 0;
      send_idle         = 1'b1;
      recv_idle         = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // radius 1 from reset: extremes, tie minimum, single item, short even
      send_point(-16'sd32768, 16'sd32767, 24'd0, 1'b0);
      send_point(16'sd32767, -16'sd32768, 24'hFFFFFF, 1'b0);
      send_point(16'sd0, 16'sd0, 24'hFFFFFF, 1'b0);
      send_point(16'sd1, -16'sd1, 24'd5, 1'b0);
      send_point(16'sd2, -16'sd2, 24'd5, 1'b1);
      send_point(-16'sd1, 16'sd1, 24'd100, 1'b1);
      send_point(16'sd3, 16'sd3, 24'd1, 1'b0);
      send_point(16'sd4, 16'sd4, 24'd0, 1'b1);
      // radius 0: every transaction is a minimum
      write_radius(5'd0);
      send_point(16'sd5, 16'sd5, 24'd7, 1'b0);
      send_point(16'sd6, 16'sd6, 24'hFFFFFF, 1'b1);
      // radius above the maximum, short odd and short even sequences
      write_radius(5'd31);
      send_point(16'sd10, 16'sd11, 24'd9, 1'b0);
      send_point(16'sd12, 16'sd13, 24'd4, 1'b0);
      send_point(16'sd14, 16'sd15, 24'd2, 1'b0);
      send_point(16'sd16, 16'sd17, 24'd4, 1'b0);
      send_point(16'sd18, 16'sd19, 24'd9, 1'b1);
      send_point(16'sd20, 16'sd21, 24'd3, 1'b0);
      send_point(16'sd22, 16'sd23, 24'd1, 1'b0);
      send_point(16'sd24, 16'sd25, 24'd1, 1'b0);
      send_point(16'sd26, 16'sd27, 24'd3, 1'b1);
      // radius change inside a sequence
      write_radius(5'd2);
      send_point(16'sd30, 16'sd31, 24'd10, 1'b0);
      send_point(16'sd32, 16'sd33, 24'd20, 1'b0);
      send_point(16'sd34, 16'sd35, 24'd30, 1'b0);
      write_radius(5'd1);
      send_point(16'sd36, 16'sd37, 24'd5, 1'b0);
      send_point(16'sd38, 16'sd39, 24'd6, 1'b1);

      target = sent_items + RANDOM_ITEMS;
      phase = 0;
      while (sent_items < target) begin
         value = (phase < PLAN_SIZE) ? RADIUS_PLAN[phase] : radius_type'($urandom_range(31));
         write_radius(value);
         send_idle = (phase % 4 != 2);
         recv_idle = (phase % 4 != 2);
         eff = (value > MAX_RADIUS) ? MAX_RADIUS : value;
         repeat (4) begin
            if ($urandom_range(99) < 75) begin
               len = 2 * eff + 1 + $urandom_range(40);
            end else begin
               len = 1 + $urandom_range(2 * eff);
            end
            case ($urandom_range(2))
               0:       shape = DIST_TIES;
               1:       shape = DIST_WIDE;
               default: shape = DIST_VALLEY;
            endcase
            send_sequence(len, shape);
         end
         phase++;
      end

      // one long sequence without idling on either side
      write_radius(5'd2);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_sequence(LONG_RUN, DIST_WIDE);
      wait_idle();

      $display("run covered %0d transactions in, %0d minima checked", item_total, result_total);
      $display("radii 0 to 31, ties, short odd and even sequences, a long stretch without idling");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
